@@ design/assert_macros.svh @@
// Assertion helpers included by the allocator design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/fidfa_pkg.sv @@
`default_nettype none

package fidfa_pkg;

   localparam int ID_BITS   = 8;
   localparam int POOL_SIZE = 1 << ID_BITS;
   localparam int CNT_BITS  = ID_BITS + 1;

   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_ALLOC = 2'd1;
   localparam logic [1:0] ACT_FREE  = 2'd2;

   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_BAD_RANGE    = 2'd1;
   localparam logic [1:0] ST_EMPTY        = 2'd2;
   localparam logic [1:0] ST_ALREADY_FREE = 2'd3;

   typedef logic [ID_BITS-1:0]  id_type;
   typedef logic [CNT_BITS-1:0] count_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] range_start;
      logic [7:0] range_end;
      logic [7:0] release_id;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] granted_id;
   } rsp_type;

   function automatic logic too_wide(input logic [7:0] v);
      return 32'(v) >= POOL_SIZE;
   endfunction

   function automatic id_type id_of(input logic [7:0] v);
      return ID_BITS'(v);
   endfunction

endpackage

`default_nettype wire

@@ design/fidfa_ram.sv @@
`default_nettype none

module fidfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ design/fifo_id_free_list_allocator.sv @@
// Channel | Direction | Handshake           | Word
// req     | in        | req_valid/req_stall | fidfa_pkg::req_type
// rsp     | out       | rsp_valid/rsp_stall | fidfa_pkg::rsp_type
//
// Action 3, rejected requests and allocate on an empty pool: answered from IDLE on accept.
// Free and allocate: pass through FREE_CHK or ALLOC, which use the registered memory read.
// Add-range: the ADD state walks from start to end, one identifier checked per cycle.
// After reset a clearing pass zeroes all 256 bitmap entries; req_stall is high.
// A result waits in the output register; req_stall is high while a request
// is in progress or while a held result is stalled.
`default_nettype none

module fifo_id_free_list_allocator (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire fidfa_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output fidfa_pkg::rsp_type      rsp_data
);

   `include "assert_macros.svh"

   typedef enum logic [2:0] {
      CLEAR,
      IDLE,
      ADD,
      ALLOC,
      FREE_CHK
   } state_type;

   state_type              state_ff, state_in;
   fidfa_pkg::id_type      head_ff, head_in;
   fidfa_pkg::id_type      tail_ff, tail_in;
   fidfa_pkg::count_type   count_ff, count_in;
   fidfa_pkg::id_type      cur_ff, cur_in;
   fidfa_pkg::id_type      last_ff, last_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   fidfa_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   load;
   logic                   ram_we;
   fidfa_pkg::id_type      ram_wdata;
   fidfa_pkg::id_type      ram_rdata;
   fidfa_pkg::id_type      rel_id;
   logic                   map_we;
   fidfa_pkg::id_type      map_waddr;
   logic                   map_wdata;
   fidfa_pkg::id_type      map_raddr;
   logic                   map_rdata;

   fidfa_ram #(
      .WIDTH(fidfa_pkg::ID_BITS),
      .DEPTH(fidfa_pkg::POOL_SIZE)
   ) u_queue (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (ram_wdata),
      .rd_addr (head_ff),
      .rd_data (ram_rdata)
   );

   fidfa_ram #(
      .WIDTH(1),
      .DEPTH(fidfa_pkg::POOL_SIZE)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   assign req_stall = (state_ff != IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rel_id    = fidfa_pkg::id_of(req_data.release_id);

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      cur_in      = cur_ff;
      last_in     = last_ff;
      ram_we      = 1'b0;
      ram_wdata   = cur_ff;
      map_we      = 1'b0;
      map_waddr   = cur_ff;
      map_wdata   = 1'b0;
      map_raddr   = cur_ff;
      load        = 1'b0;
      rsp_data_in = rsp_data_ff;

      unique case (state_ff)
         CLEAR: begin
            map_we = 1'b1;
            if (cur_ff == '1) begin
               state_in = IDLE;
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end
         IDLE: begin
            // The bitmap read for the first identifier is launched on the accept edge.
            map_raddr = (req_data.action == fidfa_pkg::ACT_FREE) ? rel_id :
                        fidfa_pkg::id_of(req_data.range_start);
            if (accept) begin
               rsp_data_in.status     = fidfa_pkg::ST_OK;
               rsp_data_in.granted_id = 8'd0;
               case (req_data.action)
                  fidfa_pkg::ACT_ADD: begin
                     if ((req_data.range_start > req_data.range_end) ||
                         fidfa_pkg::too_wide(req_data.range_start) ||
                         fidfa_pkg::too_wide(req_data.range_end)) begin
                        rsp_data_in.status = fidfa_pkg::ST_BAD_RANGE;
                        load               = 1'b1;
                     end else begin
                        cur_in   = fidfa_pkg::id_of(req_data.range_start);
                        last_in  = fidfa_pkg::id_of(req_data.range_end);
                        state_in = ADD;
                     end
                  end
                  fidfa_pkg::ACT_ALLOC: begin
                     if (count_ff == '0) begin
                        rsp_data_in.status = fidfa_pkg::ST_EMPTY;
                        load               = 1'b1;
                     end else begin
                        state_in = ALLOC;
                     end
                  end
                  fidfa_pkg::ACT_FREE: begin
                     if (fidfa_pkg::too_wide(req_data.release_id)) begin
                        rsp_data_in.status = fidfa_pkg::ST_BAD_RANGE;
                        load               = 1'b1;
                     end else begin
                        cur_in   = rel_id;
                        state_in = FREE_CHK;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         ADD: begin
            map_raddr = cur_ff + 1'b1;
            if (!map_rdata &&
                (count_ff < fidfa_pkg::CNT_BITS'(fidfa_pkg::POOL_SIZE))) begin
               ram_we    = 1'b1;
               tail_in   = tail_ff + 1'b1;
               count_in  = count_ff + 1'b1;
               map_we    = 1'b1;
               map_wdata = 1'b1;
            end
            if (cur_ff == last_ff) begin
               load     = 1'b1;
               state_in = IDLE;
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end
         ALLOC: begin
            // The queue read was launched at the head address on the accept edge.
            head_in                = head_ff + 1'b1;
            count_in               = count_ff - 1'b1;
            map_we                 = 1'b1;
            map_waddr              = ram_rdata;
            rsp_data_in.granted_id = 8'(ram_rdata);
            load                   = 1'b1;
            state_in               = IDLE;
         end
         FREE_CHK: begin
            if (map_rdata) begin
               rsp_data_in.status = fidfa_pkg::ST_ALREADY_FREE;
            end else begin
               ram_we    = 1'b1;
               tail_in   = tail_ff + 1'b1;
               count_in  = count_ff + 1'b1;
               map_we    = 1'b1;
               map_wdata = 1'b1;
            end
            load     = 1'b1;
            state_in = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   `ASSERT_CLK(a_count_bound, clock, reset, count_ff <= fidfa_pkg::CNT_BITS'(fidfa_pkg::POOL_SIZE), "free count beyond pool size")
   `ASSERT_CLK(a_no_overwrite, clock, reset, load |-> !(rsp_valid_ff && rsp_stall), "result loaded over a stalled word")
   `ASSERT_CLK(a_alloc_nonempty, clock, reset, (state_ff == ALLOC) |-> (count_ff != '0), "allocate issued on an empty pool")
   `ASSERT_CLK(a_pointers_wrap, clock, reset, ((count_ff == '0) || (count_ff == fidfa_pkg::CNT_BITS'(fidfa_pkg::POOL_SIZE))) |-> (head_ff == tail_ff), "head and tail disagree with count")

endmodule

`default_nettype wire

@@ tb/fifo_id_free_list_allocator_test.sv @@
`timescale 1ns / 100ps

module fifo_id_free_list_allocator_test;

   // Action 3 has no name in the package; the block answers it with OK and no change.
   localparam logic [1:0] ACT_IDLE = 2'd3;
   localparam int RANDOM_ITEMS = 1330;
   localparam int PHASE_ITEMS  = 300;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AFTER   = 300;

   typedef struct {
      fidfa_pkg::req_type word;
      bit                 typed;
      fidfa_pkg::rsp_type want;
   } stim_row_type;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   fidfa_pkg::req_type req_data  = '0;
   logic               rsp_stall = 1'b0;
   logic               req_stall;
   logic               rsp_valid;
   fidfa_pkg::rsp_type rsp_data;

   // Expected state of the allocator: pool contents in hand-out order and presence bits.
   fidfa_pkg::id_type  pool_order[$];
   bit                 in_pool[fidfa_pkg::POOL_SIZE];
   fidfa_pkg::rsp_type pending_rsp[$];
   fidfa_pkg::id_type  issued_ids[$];
   stim_row_type       directed_rows[$];
   int                 error_count = 0;
   int                 rsp_seen    = 0;
   int                 burst_left  = 0;

   always #5 clock = ~clock;

   fifo_id_free_list_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   function automatic bit beyond_pool(input logic [7:0] v);
      return int'(v) >= fidfa_pkg::POOL_SIZE;
   endfunction

   function automatic fidfa_pkg::rsp_type allocator_predict(input fidfa_pkg::req_type w);
      fidfa_pkg::rsp_type r;
      r.status     = fidfa_pkg::ST_OK;
      r.granted_id = '0;
      case (w.action)
         fidfa_pkg::ACT_ADD: begin
            if (w.range_start > w.range_end || beyond_pool(w.range_start) ||
                beyond_pool(w.range_end)) begin
               r.status = fidfa_pkg::ST_BAD_RANGE;
            end else begin
               for (int i = int'(w.range_start); i <= int'(w.range_end); i++) begin
                  if (!in_pool[i]) begin
                     pool_order = {pool_order, fidfa_pkg::id_type'(i)};
                     in_pool[i] = 1'b1;
                  end
               end
            end
         end
         fidfa_pkg::ACT_ALLOC: begin
            if (pool_order.size() == 0) begin
               r.status = fidfa_pkg::ST_EMPTY;
            end else begin
               r.granted_id = pool_order.pop_front();
               in_pool[r.granted_id] = 1'b0;
            end
         end
         fidfa_pkg::ACT_FREE: begin
            if (beyond_pool(w.release_id)) begin
               r.status = fidfa_pkg::ST_BAD_RANGE;
            end else if (in_pool[w.release_id]) begin
               r.status = fidfa_pkg::ST_ALREADY_FREE;
            end else begin
               pool_order = {pool_order, fidfa_pkg::id_type'(w.release_id)};
               in_pool[w.release_id] = 1'b1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic stim_row_type make_row(input logic [1:0] act, input logic [7:0] first,
                                             input logic [7:0] last, input logic [7:0] rel,
                                             input bit typed, input logic [1:0] st,
                                             input logic [7:0] gid);
      stim_row_type s;
      s.word.action      = act;
      s.word.range_start = first;
      s.word.range_end   = last;
      s.word.release_id  = rel;
      s.typed            = typed;
      s.want.status      = st;
      s.want.granted_id  = gid;
      return s;
   endfunction

   // Drain phases mostly allocate so the pool runs dry; fill phases add and free.
   function automatic fidfa_pkg::req_type random_word(input bit drain);
      fidfa_pkg::req_type w;
      int                 pick;
      int                 sel;
      int                 idx;
      w.range_start = 8'($urandom);
      w.range_end   = 8'($urandom);
      w.release_id  = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         w.action = ACT_IDLE;
      end else if (pick < (drain ? 93 : 33)) begin
         w.action = fidfa_pkg::ACT_ALLOC;
      end else if (pick < (drain ? 97 : 58)) begin
         w.action = fidfa_pkg::ACT_FREE;
         sel = $urandom_range(0, 9);
         if (sel < 7 && issued_ids.size() > 0) begin
            idx = $urandom_range(0, issued_ids.size() - 1);
            w.release_id = issued_ids[idx];
            issued_ids.delete(idx);
         end else if (sel == 9 && pool_order.size() > 0) begin
            w.release_id = pool_order[$urandom_range(0, pool_order.size() - 1)];
         end
      end else begin
         w.action = fidfa_pkg::ACT_ADD;
         sel = $urandom_range(0, 99);
         if (sel < 6) begin
            w.range_start = 8'($urandom_range(1, 255));
            w.range_end   = 8'($urandom_range(0, w.range_start - 1));
         end else if (sel < 8) begin
            w.range_start = 8'($urandom_range(0, 40));
            w.range_end   = 8'($urandom_range(200, 255));
         end else begin
            w.range_end = 8'((int'(w.range_start) + $urandom_range(0, drain ? 1 : 7) > 255) ?
                             255 : int'(w.range_start) + $urandom_range(0, drain ? 1 : 7));
            if (w.range_end < w.range_start) w.range_end = w.range_start;
         end
      end
      return w;
   endfunction

   // Holds the word until accepted, then records its expected result and paces the next one.
   task automatic offer(input fidfa_pkg::req_type w, input bit typed,
                        input fidfa_pkg::rsp_type want);
      fidfa_pkg::rsp_type got;
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      got = allocator_predict(w);
      pending_rsp = {pending_rsp, (typed ? want : got)};
      if (w.action == fidfa_pkg::ACT_ALLOC && got.status == fidfa_pkg::ST_OK) begin
         issued_ids = {issued_ids, got.granted_id};
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 12);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      fidfa_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            $display("%0t: word with none expected, status %0d granted_id %0d",
                     $time, rsp_data.status, rsp_data.granted_id);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.granted_id !== want.granted_id) begin
               $display("%0t: granted_id expected %0d actual %0d",
                        $time, want.granted_id, rsp_data.granted_id);
               error_count++;
            end
         end
      end
   end

   initial begin : rsp_pacing
      int mode;
      int span;
      bit held;
      held = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         // One long hold-off so the output register fills and the input backs up.
         if (!held && rsp_seen >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         mode = $urandom_range(0, 2);
         span = $urandom_range(10, 150);
         repeat (span) begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      #40000000;
      $display("fifo_id_free_list_allocator regression: fail");
      $finish;
   end

   initial begin
      directed_rows = {directed_rows, make_row(fidfa_pkg::ACT_ALLOC, 8'h00, 8'h00, 8'h00,
                                               1'b1, fidfa_pkg::ST_EMPTY, 8'd0)};
      directed_rows = {directed_rows, make_row(fidfa_pkg::ACT_FREE, 8'h00, 8'h00, 8'h00,
                                               1'b1, fidfa_pkg::ST_OK, 8'd0)};
      directed_rows = {directed_rows, make_row(fidfa_pkg::ACT_FREE, 8'hff, 8'hff, 8'h00,
                                               1'b1, fidfa_pkg::ST_ALREADY_FREE, 8'd0)};
      directed_rows = {directed_rows, make_row(fidfa_pkg::ACT_ALLOC, 8'h00, 8'h00, 8'h00,
                                               1'b1, fidfa_pkg::ST_OK, 8'd0)};
      directed_rows = {directed_rows, make_row(fidfa_pkg::ACT_ALLOC, 8'h00, 8'h00, 8'h00,
                                               1'b1, fidfa_pkg::ST_EMPTY, 8'd0)};
      directed_rows = {directed_rows, make_row(fidfa_pkg::ACT_ADD, 8'd10, 8'd3, 8'h00,
                                               1'b1, fidfa_pkg::ST_BAD_RANGE, 8'd0)};
      directed_rows = {directed_rows, make_row(fidfa_pkg::ACT_ADD, 8'd255, 8'd0, 8'hff,
                                               1'b1, fidfa_pkg::ST_BAD_RANGE, 8'd0)};
      directed_rows = {directed_rows, make_row(fidfa_pkg::ACT_ADD, 8'd0, 8'd255, 8'h00,
                                               1'b1, fidfa_pkg::ST_OK, 8'd0)};
      directed_rows = {directed_rows, make_row(fidfa_pkg::ACT_FREE, 8'h00, 8'h00, 8'd255,
                                               1'b1, fidfa_pkg::ST_ALREADY_FREE, 8'd0)};
      directed_rows = {directed_rows, make_row(fidfa_pkg::ACT_FREE, 8'h00, 8'h00, 8'd128,
                                               1'b1, fidfa_pkg::ST_ALREADY_FREE, 8'd0)};
      directed_rows = {directed_rows, make_row(fidfa_pkg::ACT_ADD, 8'd0, 8'd255, 8'h00,
                                               1'b1, fidfa_pkg::ST_OK, 8'd0)};
      directed_rows = {directed_rows, make_row(fidfa_pkg::ACT_ALLOC, 8'h00, 8'h00, 8'h00,
                                               1'b1, fidfa_pkg::ST_OK, 8'd0)};
      directed_rows = {directed_rows, make_row(fidfa_pkg::ACT_ALLOC, 8'hff, 8'hff, 8'hff,
                                               1'b1, fidfa_pkg::ST_OK, 8'd1)};
      directed_rows = {directed_rows, make_row(fidfa_pkg::ACT_FREE, 8'h00, 8'h00, 8'd0,
                                               1'b0, fidfa_pkg::ST_OK, 8'd0)};
      directed_rows = {directed_rows, make_row(fidfa_pkg::ACT_ADD, 8'd255, 8'd255, 8'h00,
                                               1'b0, fidfa_pkg::ST_OK, 8'd0)};
      directed_rows = {directed_rows, make_row(fidfa_pkg::ACT_ADD, 8'd0, 8'd1, 8'h00,
                                               1'b0, fidfa_pkg::ST_OK, 8'd0)};
      directed_rows = {directed_rows, make_row(ACT_IDLE, 8'hff, 8'hff, 8'hff,
                                               1'b1, fidfa_pkg::ST_OK, 8'd0)};
      directed_rows = {directed_rows, make_row(ACT_IDLE, 8'h00, 8'h00, 8'h00,
                                               1'b1, fidfa_pkg::ST_OK, 8'd0)};
      directed_rows = {directed_rows, make_row(fidfa_pkg::ACT_ALLOC, 8'h00, 8'h00, 8'h00,
                                               1'b0, fidfa_pkg::ST_OK, 8'd0)};
      directed_rows = {directed_rows, make_row(fidfa_pkg::ACT_FREE, 8'hff, 8'hff, 8'd170,
                                               1'b0, fidfa_pkg::ST_OK, 8'd0)};
      directed_rows = {directed_rows, make_row(fidfa_pkg::ACT_ADD, 8'd85, 8'd85, 8'h55,
                                               1'b0, fidfa_pkg::ST_OK, 8'd0)};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         offer(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
      end
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         offer(random_word(((k / PHASE_ITEMS) % 2) == 0), 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("fifo_id_free_list_allocator regression: pass");
      end else begin
         $display("fifo_id_free_list_allocator regression: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/fidfa_pkg.sv
design/fidfa_ram.sv
design/fifo_id_free_list_allocator.sv
tb/fifo_id_free_list_allocator_test.sv
